### hdl/link_failover_state_machine_top_assert.svh
// ----------------------------------------------------------------------------
// Link failover assertion macros
// Shared property forms for the link failover checker. Each expects clk and
// arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LINK_FAILOVER_STATE_MACHINE_TOP_ASSERT_SVH
`define LINK_FAILOVER_STATE_MACHINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lfsm_pkg.sv
// ----------------------------------------------------------------------------
// Link failover package
// Mode codes, register indexes, reset values and the structs that travel
// between the link failover modules.
// ----------------------------------------------------------------------------
package lfsm_pkg;

	typedef enum logic [2:0] {
		MODE_DISCONNECTED   = 3'd0,
		MODE_PRI_CONNECTING = 3'd1,
		MODE_PRI_CONNECTED  = 3'd2,
		MODE_FB_CONNECTING  = 3'd3,
		MODE_FB_CONNECTED   = 3'd4,
		MODE_STANDALONE     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		REG_HEARTBEAT_TIMEOUT = 2'd0,
		REG_DISCOVERY_TIMEOUT = 2'd1,
		REG_FALLBACK_DELAY    = 2'd2,
		REG_FALLBACK_ENABLED  = 2'd3
	} reg_idx_t;

	localparam logic [31:0] HEARTBEAT_TIMEOUT_RST = 32'd10000;
	localparam logic [31:0] DISCOVERY_TIMEOUT_RST = 32'd10000;
	localparam logic [31:0] FALLBACK_DELAY_RST    = 32'd30000;
	localparam logic        FALLBACK_ENABLED_RST  = 1'b1;

	typedef struct packed {
		logic [31:0] heartbeat_timeout_ms;
		logic [31:0] discovery_timeout_ms;
		logic [31:0] fallback_delay_ms;
		logic        fallback_enabled;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        gateway_known;
		logic [31:0] gateway_last_seen_ms;
		logic        fallback_link_up;
	} item_t;

	typedef struct packed {
		mode_t mode;
		logic  gateway_reachable;
		logic  flush_pulse;
		logic  mode_changed;
	} result_t;

endpackage

### hdl/lfsm_next.sv
// ----------------------------------------------------------------------------
// Link failover next-mode logic
// Evaluates one tick against the current mode and entry time and forms the
// result word, including the mode to be stored.
// ----------------------------------------------------------------------------
module lfsm_next (
	input  lfsm_pkg::cfg_t    cfg,
	input  lfsm_pkg::item_t   item,
	input  lfsm_pkg::mode_t   cur_mode,
	input  logic [31:0]       entry_time,
	output lfsm_pkg::result_t result
);

	logic [31:0]     age;
	logic [31:0]     elapsed;
	logic            up;
	logic            fb;
	lfsm_pkg::mode_t lost;
	lfsm_pkg::mode_t next_mode;
	logic            changed;

	// Both ages are modulo 2^32, so a wrapped clock still gives the right age.
	assign age     = item.now_ms - item.gateway_last_seen_ms;
	assign elapsed = item.now_ms - entry_time;
	assign up      = item.gateway_known && (age < cfg.heartbeat_timeout_ms);
	assign fb      = cfg.fallback_enabled && item.fallback_link_up;
	assign lost    = cfg.fallback_enabled ? lfsm_pkg::MODE_FB_CONNECTING
	                                      : lfsm_pkg::MODE_STANDALONE;

	always_comb begin
		next_mode = cur_mode;
		unique case (cur_mode)
			lfsm_pkg::MODE_DISCONNECTED: begin
				next_mode = lfsm_pkg::MODE_PRI_CONNECTING;
			end
			lfsm_pkg::MODE_PRI_CONNECTING: begin
				if (up) begin
					next_mode = lfsm_pkg::MODE_PRI_CONNECTED;
				end else if (elapsed >= cfg.discovery_timeout_ms) begin
					next_mode = lost;
				end
			end
			lfsm_pkg::MODE_PRI_CONNECTED: begin
				if (!up) begin
					next_mode = lost;
				end
			end
			lfsm_pkg::MODE_FB_CONNECTING: begin
				if (up) begin
					next_mode = lfsm_pkg::MODE_PRI_CONNECTED;
				end else if (fb) begin
					next_mode = lfsm_pkg::MODE_FB_CONNECTED;
				end else if (elapsed >= cfg.fallback_delay_ms) begin
					next_mode = lfsm_pkg::MODE_STANDALONE;
				end
			end
			lfsm_pkg::MODE_FB_CONNECTED: begin
				if (up) begin
					next_mode = lfsm_pkg::MODE_PRI_CONNECTED;
				end else if (!fb) begin
					next_mode = lost;
				end
			end
			// Standalone, and any stray code, behaves as standalone.
			default: begin
				if (up) begin
					next_mode = lfsm_pkg::MODE_PRI_CONNECTED;
				end else if (fb) begin
					next_mode = lfsm_pkg::MODE_FB_CONNECTED;
				end
			end
		endcase
	end

	assign changed = (next_mode != cur_mode);

	always_comb begin
		result.mode              = next_mode;
		result.gateway_reachable = (next_mode == lfsm_pkg::MODE_PRI_CONNECTED) ||
		                           (next_mode == lfsm_pkg::MODE_FB_CONNECTED);
		result.flush_pulse       = changed && (next_mode == lfsm_pkg::MODE_PRI_CONNECTED);
		result.mode_changed      = changed;
	end

endmodule

### hdl/link_failover_state_machine_top.sv
// ----------------------------------------------------------------------------
// Link failover state machine
// Keeps the transport mode of a gateway link with a fallback link and reports
// the mode, reachability and a flush pulse once per evaluation tick.
//
//   channel   handshake            payload
//   item      item_valid/stall     now_ms, gateway_known,
//                                  gateway_last_seen_ms, fallback_link_up
//   res       res_valid/stall      mode, gateway_reachable, flush_pulse,
//                                  mode_changed
//   cfg       cfg_valid/ready      cfg_index, cfg_data
//
// One word per cycle sustained while res_stall is low. A word passes
// through the input register and then the result register. The mode and
// entry time are updated as a word moves into the result register.
// res_stall holds the result register, and item_stall rises only when both
// registers are full. Reset clears mode, entry time, all configuration
// registers to their defaults and both valid flags.
// ----------------------------------------------------------------------------
module link_failover_state_machine_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [31:0] now_ms,
	input  logic        gateway_known,
	input  logic [31:0] gateway_last_seen_ms,
	input  logic        fallback_link_up,

	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  mode,
	output logic        gateway_reachable,
	output logic        flush_pulse,
	output logic        mode_changed,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	lfsm_pkg::cfg_t    cfg_q;
	lfsm_pkg::mode_t   mode_q;
	logic [31:0]       entry_time_q;

	lfsm_pkg::item_t   item_s1;
	logic              valid_s1;
	lfsm_pkg::result_t res_s2;
	logic              valid_s2;

	lfsm_pkg::result_t next_res;
	logic              adv_s1;
	logic              take_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heartbeat_timeout_ms <= lfsm_pkg::HEARTBEAT_TIMEOUT_RST;
			cfg_q.discovery_timeout_ms <= lfsm_pkg::DISCOVERY_TIMEOUT_RST;
			cfg_q.fallback_delay_ms    <= lfsm_pkg::FALLBACK_DELAY_RST;
			cfg_q.fallback_enabled     <= lfsm_pkg::FALLBACK_ENABLED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lfsm_pkg::REG_HEARTBEAT_TIMEOUT: cfg_q.heartbeat_timeout_ms <= cfg_data;
				lfsm_pkg::REG_DISCOVERY_TIMEOUT: cfg_q.discovery_timeout_ms <= cfg_data;
				lfsm_pkg::REG_FALLBACK_DELAY:    cfg_q.fallback_delay_ms    <= cfg_data;
				default:                         cfg_q.fallback_enabled     <= cfg_data[0];
			endcase
		end
	end

	// The word in the input register moves on whenever the result register
	// is empty or being drained this cycle.
	assign adv_s1     = valid_s1 && (!valid_s2 || !res_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign take_item  = item_valid && !item_stall;

	lfsm_next u_next (
		.cfg        (cfg_q),
		.item       (item_s1),
		.cur_mode   (mode_q),
		.entry_time (entry_time_q),
		.result     (next_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			mode_q       <= lfsm_pkg::MODE_DISCONNECTED;
			entry_time_q <= 32'd0;
		end else begin
			if (take_item) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s1 && next_res.mode_changed) begin
				mode_q       <= next_res.mode;
				entry_time_q <= item_s1.now_ms;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			item_s1.now_ms               <= now_ms;
			item_s1.gateway_known        <= gateway_known;
			item_s1.gateway_last_seen_ms <= gateway_last_seen_ms;
			item_s1.fallback_link_up     <= fallback_link_up;
		end
		if (adv_s1) begin
			res_s2 <= next_res;
		end
	end

	assign res_valid         = valid_s2;
	assign mode              = res_s2.mode;
	assign gateway_reachable = res_s2.gateway_reachable;
	assign flush_pulse       = res_s2.flush_pulse;
	assign mode_changed      = res_s2.mode_changed;

endmodule

### hdl/lfsm_checker.sv
// ----------------------------------------------------------------------------
// Link failover checker
// Watches the ports of the link failover top level and checks the result
// words for consistency over time.
// ----------------------------------------------------------------------------
`include "link_failover_state_machine_top_assert.svh"

module lfsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [2:0]  mode,
	input logic        gateway_reachable,
	input logic        flush_pulse,
	input logic        mode_changed
);

	logic       reach_mode;
	logic       reach_ok;
	logic       flush_ok;
	logic       res_hold;
	logic [5:0] res_word;

	assign reach_mode = (mode == lfsm_pkg::MODE_PRI_CONNECTED) ||
	                    (mode == lfsm_pkg::MODE_FB_CONNECTED);
	assign reach_ok   = (gateway_reachable == reach_mode);
	// A flush pulse marks the entry into primary connected.
	assign flush_ok   = mode_changed && (mode == lfsm_pkg::MODE_PRI_CONNECTED);
	assign res_hold   = res_valid && res_stall;
	assign res_word   = {mode, gateway_reachable, flush_pulse, mode_changed};

	`LFSM_ASSERT_NOW(a_reach_matches_mode, res_valid, reach_ok, "reachable flag disagrees")

	`LFSM_ASSERT_NOW(a_flush_on_entry, res_valid && flush_pulse, flush_ok, "flush without entry")

	// Disconnected is left on the first tick and never entered again.
	`LFSM_ASSERT_NOW(a_never_disconnected, res_valid, mode != 3'd0, "result reports disconnected")

	`LFSM_ASSERT_NEXT(a_stalled_word_holds, res_hold, res_valid && $stable(res_word), "word changed")

	// The input side waits only behind a full and stalled result register.
	`LFSM_ASSERT_NOW(a_stall_needs_full, item_valid && item_stall, res_hold, "needless input stall")

endmodule

bind link_failover_state_machine_top lfsm_checker u_lfsm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item_valid),
	.item_stall        (item_stall),
	.res_valid         (res_valid),
	.res_stall         (res_stall),
	.mode              (mode),
	.gateway_reachable (gateway_reachable),
	.flush_pulse       (flush_pulse),
	.mode_changed      (mode_changed)
);

### tb/tb_link_failover_state_machine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link failover state machine testbench
// Drives evaluation ticks into the block and predicts the mode, reachability,
// flush pulse and change flag of each result word. A directed run walks the
// mode transitions, with a random exit from primary connecting. Random phases
// follow, each with its own registers and one of four sender gap and stall mixes.
// ----------------------------------------------------------------------------
module tb_link_failover_state_machine_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [31:0] now_ms = '0;
	logic        gateway_known = 1'b0;
	logic [31:0] gateway_last_seen_ms = '0;
	logic        fallback_link_up = 1'b0;

	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  mode;
	logic        gateway_reachable;
	logic        flush_pulse;
	logic        mode_changed;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	link_failover_state_machine_top u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.item_valid           (item_valid),
		.item_stall           (item_stall),
		.now_ms               (now_ms),
		.gateway_known        (gateway_known),
		.gateway_last_seen_ms (gateway_last_seen_ms),
		.fallback_link_up     (fallback_link_up),
		.res_valid            (res_valid),
		.res_stall            (res_stall),
		.mode                 (mode),
		.gateway_reachable    (gateway_reachable),
		.flush_pulse          (flush_pulse),
		.mode_changed         (mode_changed),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data)
	);

	always #4 clk = ~clk;

	// Predicted block state and register copies.
	lfsm_pkg::mode_t   link_mode = lfsm_pkg::MODE_DISCONNECTED;
	logic [31:0]       mode_entry_ms = '0;
	logic [31:0]       hb_timeout = lfsm_pkg::HEARTBEAT_TIMEOUT_RST;
	logic [31:0]       disc_timeout = lfsm_pkg::DISCOVERY_TIMEOUT_RST;
	logic [31:0]       fb_delay = lfsm_pkg::FALLBACK_DELAY_RST;
	logic              fb_enable = lfsm_pkg::FALLBACK_ENABLED_RST;

	lfsm_pkg::item_t   tick_q[$];
	lfsm_pkg::result_t expected_status_q[$];
	lfsm_pkg::item_t   on_wire;
	lfsm_pkg::result_t got_status;
	lfsm_pkg::result_t want_status;
	int                error_count = 0;
	int                send_idle_pct = 0;
	int                stall_pct = 0;

	// Scenario state of the random ticks.
	logic [31:0] clock_ms = '0;
	logic        gw_alive = 1'b1;
	logic        fb_alive = 1'b0;

	function automatic lfsm_pkg::result_t next_link_status(lfsm_pkg::item_t it);
		logic              up;
		logic              fb;
		logic [31:0]       age;
		logic [31:0]       elapsed;
		lfsm_pkg::mode_t   lost;
		lfsm_pkg::mode_t   nxt;
		lfsm_pkg::result_t r;
		age = it.now_ms - it.gateway_last_seen_ms;
		up = it.gateway_known && (age < hb_timeout);
		fb = fb_enable && it.fallback_link_up;
		elapsed = it.now_ms - mode_entry_ms;
		lost = fb_enable ? lfsm_pkg::MODE_FB_CONNECTING : lfsm_pkg::MODE_STANDALONE;
		nxt = link_mode;
		case (link_mode)
			lfsm_pkg::MODE_DISCONNECTED: nxt = lfsm_pkg::MODE_PRI_CONNECTING;
			lfsm_pkg::MODE_PRI_CONNECTING: begin
				if (up)
					nxt = lfsm_pkg::MODE_PRI_CONNECTED;
				else if (elapsed >= disc_timeout)
					nxt = lost;
			end
			lfsm_pkg::MODE_PRI_CONNECTED: begin
				if (!up)
					nxt = lost;
			end
			lfsm_pkg::MODE_FB_CONNECTING: begin
				if (up)
					nxt = lfsm_pkg::MODE_PRI_CONNECTED;
				else if (fb)
					nxt = lfsm_pkg::MODE_FB_CONNECTED;
				else if (elapsed >= fb_delay)
					nxt = lfsm_pkg::MODE_STANDALONE;
			end
			lfsm_pkg::MODE_FB_CONNECTED: begin
				if (up)
					nxt = lfsm_pkg::MODE_PRI_CONNECTED;
				else if (!fb)
					nxt = lost;
			end
			default: begin
				if (up)
					nxt = lfsm_pkg::MODE_PRI_CONNECTED;
				else if (fb)
					nxt = lfsm_pkg::MODE_FB_CONNECTED;
			end
		endcase
		r.mode_changed = (nxt != link_mode);
		if (r.mode_changed) begin
			link_mode = nxt;
			mode_entry_ms = it.now_ms;
		end
		r.mode = link_mode;
		r.gateway_reachable = (link_mode == lfsm_pkg::MODE_PRI_CONNECTED) ||
			(link_mode == lfsm_pkg::MODE_FB_CONNECTED);
		r.flush_pulse = r.mode_changed && (link_mode == lfsm_pkg::MODE_PRI_CONNECTED);
		return r;
	endfunction

	// A word is predicted at the edge where the block takes it.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (item_valid)
				expected_status_q.push_back(next_link_status(on_wire));
			if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				on_wire = tick_q.pop_front();
				item_valid <= 1'b1;
				now_ms <= on_wire.now_ms;
				gateway_known <= on_wire.gateway_known;
				gateway_last_seen_ms <= on_wire.gateway_last_seen_ms;
				fallback_link_up <= on_wire.fallback_link_up;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			got_status.mode = lfsm_pkg::mode_t'(mode);
			got_status.gateway_reachable = gateway_reachable;
			got_status.flush_pulse = flush_pulse;
			got_status.mode_changed = mode_changed;
			if (expected_status_q.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result word: mode %0d reach %0b flush %0b changed %0b",
					$time, mode, gateway_reachable, flush_pulse, mode_changed);
			end else begin
				want_status = expected_status_q.pop_front();
				if (got_status !== want_status) begin
					error_count++;
					$display("%0t: mismatch: expected mode %0d reach %0b flush %0b changed %0b",
						$time, want_status.mode, want_status.gateway_reachable,
						want_status.flush_pulse, want_status.mode_changed);
					$display("%0t:           actual   mode %0d reach %0b flush %0b changed %0b",
						$time, mode, gateway_reachable, flush_pulse, mode_changed);
				end
			end
		end
		res_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	task automatic push_tick(logic [31:0] t, logic known, logic [31:0] seen, logic link);
		lfsm_pkg::item_t it;
		it.now_ms = t;
		it.gateway_known = known;
		it.gateway_last_seen_ms = seen;
		it.fallback_link_up = link;
		tick_q.push_back(it);
	endtask

	// Waits until every word has gone through and the block is idle. The
	// check runs at the falling edge, once the driver and monitor have settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || item_valid || expected_status_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Called right after a rising edge.
	task automatic write_reg(lfsm_pkg::reg_idx_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			lfsm_pkg::REG_HEARTBEAT_TIMEOUT: hb_timeout = data;
			lfsm_pkg::REG_DISCOVERY_TIMEOUT: disc_timeout = data;
			lfsm_pkg::REG_FALLBACK_DELAY: fb_delay = data;
			default: fb_enable = data[0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Ticks follow a moving clock with gateway and fallback link episodes;
	// one tick in ten is pure noise.
	task automatic queue_random_ticks(int count, int unsigned span);
		lfsm_pkg::item_t it;
		logic [31:0]     age;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				it.now_ms = $urandom;
				it.gateway_known = 1'($urandom_range(1));
				it.gateway_last_seen_ms = $urandom;
				it.fallback_link_up = 1'($urandom_range(1));
			end else begin
				if ($urandom_range(9) == 0)
					gw_alive = !gw_alive;
				if ($urandom_range(7) == 0)
					fb_alive = !fb_alive;
				clock_ms += $urandom_range(0, span);
				if (gw_alive)
					age = (hb_timeout == 0) ? 32'd0 : $urandom_range(0, hb_timeout - 1);
				else
					age = hb_timeout + $urandom_range(0, span);
				if ($urandom_range(15) == 0)
					age = hb_timeout - $urandom_range(1);
				it.now_ms = clock_ms;
				it.gateway_known = ($urandom_range(7) != 0);
				it.gateway_last_seen_ms = clock_ms - age;
				it.fallback_link_up = fb_alive ^ ($urandom_range(15) == 0);
			end
			tick_q.push_back(it);
		end
	endtask

	initial begin
		int          exit_sel;
		int unsigned span;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Mode 1 is entered only once per run, so its exit is picked at random.
		exit_sel = $urandom_range(2);
		if (exit_sel == 2)
			write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd0);
		push_tick(32'd0, 1'b0, 32'd0, 1'b0);
		push_tick(32'd9999, 1'b0, 32'd9999, 1'b1);
		if (exit_sel == 0)
			push_tick(32'd10000, 1'b1, 32'd1, 1'b0);
		else
			push_tick(32'd10000, 1'b1, 32'd0, 1'b0);
		wait_idle();
		write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd1);
		push_tick(32'd20000, 1'b1, 32'd20000, 1'b0);
		push_tick(32'd25000, 1'b1, 32'd15001, 1'b0);
		push_tick(32'd30000, 1'b1, 32'd20000, 1'b0);
		push_tick(32'd40000, 1'b0, 32'd0, 1'b1);
		push_tick(32'd40001, 1'b1, 32'd40001, 1'b1);
		push_tick(32'd40002, 1'b0, 32'd0, 1'b1);
		push_tick(32'd40003, 1'b0, 32'd0, 1'b0);
		push_tick(32'd70001, 1'b1, 32'd0, 1'b0);
		push_tick(32'd70002, 1'b0, 32'd70002, 1'b0);
		push_tick(32'd70003, 1'b0, 32'd0, 1'b1);
		push_tick(32'd70004, 1'b0, 32'd0, 1'b0);
		push_tick(32'd70005, 1'b1, 32'd70005, 1'b0);
		// Heartbeat age of all ones, then a fresh one across the wrap.
		push_tick(32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1);
		push_tick(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1);
		push_tick(32'd5, 1'b1, 32'hFFFF_FFFA, 1'b0);
		push_tick(32'd6, 1'b0, 32'd0, 1'b1);
		wait_idle();
		// With fallback disabled the link flag is ignored.
		write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd0);
		push_tick(32'd10, 1'b0, 32'd0, 1'b1);
		push_tick(32'd10, 1'b1, 32'd10, 1'b0);
		push_tick(32'd11, 1'b0, 32'd0, 1'b1);
		push_tick(32'd12, 1'b0, 32'd0, 1'b1);
		push_tick(32'd13, 1'b1, 32'd13, 1'b1);
		wait_idle();
		write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd1);
		push_tick(32'd14, 1'b0, 32'd0, 1'b1);
		push_tick(32'd15, 1'b0, 32'd0, 1'b1);
		wait_idle();
		// Losing the fallback link while it is disabled goes standalone.
		write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd0);
		push_tick(32'd16, 1'b0, 32'd0, 1'b1);

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			case (p)
				0: begin
					write_reg(lfsm_pkg::REG_HEARTBEAT_TIMEOUT, lfsm_pkg::HEARTBEAT_TIMEOUT_RST);
					write_reg(lfsm_pkg::REG_FALLBACK_DELAY, lfsm_pkg::FALLBACK_DELAY_RST);
					write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd1);
					span = 12000;
				end
				1: begin
					write_reg(lfsm_pkg::REG_HEARTBEAT_TIMEOUT, 32'd100);
					write_reg(lfsm_pkg::REG_DISCOVERY_TIMEOUT, 32'd50);
					write_reg(lfsm_pkg::REG_FALLBACK_DELAY, 32'd200);
					span = 80;
				end
				2: begin
					write_reg(lfsm_pkg::REG_HEARTBEAT_TIMEOUT, 32'd0);
					write_reg(lfsm_pkg::REG_DISCOVERY_TIMEOUT, 32'd0);
					write_reg(lfsm_pkg::REG_FALLBACK_DELAY, 32'd0);
					span = 20;
				end
				3: begin
					write_reg(lfsm_pkg::REG_HEARTBEAT_TIMEOUT, $urandom_range(20, 300));
					write_reg(lfsm_pkg::REG_FALLBACK_DELAY, $urandom_range(0, 400));
					write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd0);
					span = 150;
				end
				4: begin
					write_reg(lfsm_pkg::REG_HEARTBEAT_TIMEOUT, 32'hFFFF_FFFF);
					write_reg(lfsm_pkg::REG_DISCOVERY_TIMEOUT, 32'hFFFF_FFFF);
					write_reg(lfsm_pkg::REG_FALLBACK_DELAY, 32'hFFFF_FFFF);
					write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, 32'd1);
					clock_ms = 32'hFFFF_F000;
					span = 4000;
				end
				5: begin
					write_reg(lfsm_pkg::REG_HEARTBEAT_TIMEOUT, 32'd1);
					write_reg(lfsm_pkg::REG_FALLBACK_DELAY, 32'd1);
					span = 3;
				end
				default: begin
					write_reg(lfsm_pkg::REG_HEARTBEAT_TIMEOUT, $urandom_range(1, 400));
					write_reg(lfsm_pkg::REG_DISCOVERY_TIMEOUT, $urandom);
					write_reg(lfsm_pkg::REG_FALLBACK_DELAY, $urandom_range(0, 400));
					write_reg(lfsm_pkg::REG_FALLBACK_ENABLED, $urandom_range(1));
					span = 200;
				end
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 57;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 57;
				end
				default: begin
					send_idle_pct = 31;
					stall_pct = 31;
				end
			endcase
			queue_random_ticks(85, span);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_status_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
